@@ rtl/gnms_pkg.sv @@
// ----------------------------------------------------------------------------
// gnms_pkg
// Shared constants, types and helper functions for the gradient non-maximum
// suppression block.
// ----------------------------------------------------------------------------
package gnms_pkg;

	// Line store geometry and data widths.
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int MAG_BITS   = 11;
	localparam int PIX_BITS   = 8;
	localparam int ANGLE_BITS = 9;

	// Field widths of the configuration registers.
	localparam int CFG_WIDTH_BITS  = 11;
	localparam int CFG_HEIGHT_BITS = 13;

	// Derived counter widths.
	localparam int COL_BITS    = $clog2(MAX_WIDTH);
	localparam int WIDTH_BITS  = $clog2(MAX_WIDTH + 1);
	localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
	localparam int HEIGHT_BITS = $clog2(MAX_HEIGHT + 1);
	localparam int CNT_BITS    = $clog2(MAX_WIDTH * MAX_HEIGHT);
	localparam int PROD_BITS   = WIDTH_BITS + HEIGHT_BITS;
	localparam int MIN_DIM     = 3;

	// One line store entry holds the older row, the newer row and the sector.
	localparam int SECT_BITS = 2;
	localparam int LINE_BITS = 2 * MAG_BITS + SECT_BITS;

	// Configuration port.
	localparam int APB_DATA_BITS = 32;
	localparam int APB_ADDR_BITS = 4;
	localparam int REG_IDX_BITS  = 2;

	localparam logic [REG_IDX_BITS-1:0] REG_IMAGE_WIDTH      = 2'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_IMAGE_HEIGHT     = 2'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_THRESHOLD_ENABLE = 2'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_STRONG_THRESHOLD = 2'd3;

	// Register values after reset and the geometry derived from them.
	localparam int RST_IMAGE_WIDTH      = 640;
	localparam int RST_IMAGE_HEIGHT     = 480;
	localparam int RST_STRONG_THRESHOLD = 150;
	localparam int RST_LAST_IDX         = RST_IMAGE_WIDTH * RST_IMAGE_HEIGHT - 1;
	localparam int RST_TAIL_START       = RST_LAST_IDX - RST_IMAGE_WIDTH;

	// Item kinds.
	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_FLUSH = 1'b1;

	// Direction sectors and the angle limits that separate them.
	localparam logic [SECT_BITS-1:0] SECT_HORZ = 2'd0;
	localparam logic [SECT_BITS-1:0] SECT_RISE = 2'd1;
	localparam logic [SECT_BITS-1:0] SECT_VERT = 2'd2;
	localparam logic [SECT_BITS-1:0] SECT_FALL = 2'd3;

	localparam int ANG_HALF = 180;
	localparam int ANG_30   = 30;
	localparam int ANG_60   = 60;
	localparam int ANG_120  = 120;
	localparam int ANG_150  = 150;
	localparam int PIX_MAX  = 255;

	typedef logic [MAG_BITS-1:0] mag_t;
	typedef mag_t [2:0][2:0] win_t;

	typedef struct packed {
		logic [WIDTH_BITS-1:0]  width;
		logic [HEIGHT_BITS-1:0] height;
		logic [CNT_BITS-1:0]    last_idx;
		logic [CNT_BITS-1:0]    tail_start;
		logic                   thresh_en;
		logic [PIX_BITS-1:0]    strong_thr;
	} geom_t;

	function automatic logic [SECT_BITS-1:0] sector_of(input logic [ANGLE_BITS-1:0] angle);
		logic [ANGLE_BITS-1:0] d;
		logic [SECT_BITS-1:0]  s;
		// The angle never reaches three half turns, so two subtractions cover it.
		if (angle >= 2 * ANG_HALF) begin
			d = angle - ANGLE_BITS'(2 * ANG_HALF);
		end else if (angle >= ANG_HALF) begin
			d = angle - ANGLE_BITS'(ANG_HALF);
		end else begin
			d = angle;
		end
		if (d < ANG_30 || d >= ANG_150) begin
			s = SECT_HORZ;
		end else if (d < ANG_60) begin
			s = SECT_RISE;
		end else if (d < ANG_120) begin
			s = SECT_VERT;
		end else begin
			s = SECT_FALL;
		end
		return s;
	endfunction

endpackage

@@ rtl/gnms_ram.sv @@
// ----------------------------------------------------------------------------
// gnms_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module gnms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/gnms_regs.sv @@
// ----------------------------------------------------------------------------
// gnms_regs
// Configuration registers behind the APB port, with the clamped frame geometry
// and the frame counts derived from it.
// ----------------------------------------------------------------------------
module gnms_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [gnms_pkg::APB_ADDR_BITS-1:0]   paddr,
	input  logic [gnms_pkg::APB_DATA_BITS-1:0]   pwdata,
	output logic [gnms_pkg::APB_DATA_BITS-1:0]   prdata,
	output logic                                 pready,
	output gnms_pkg::geom_t                      geom,
	output logic                                 restart
);

	logic [gnms_pkg::CFG_WIDTH_BITS-1:0]  image_width_q;
	logic [gnms_pkg::CFG_HEIGHT_BITS-1:0] image_height_q;
	logic                                 threshold_enable_q;
	logic [gnms_pkg::PIX_BITS-1:0]        strong_threshold_q;

	logic                                 wr_en;
	logic [gnms_pkg::REG_IDX_BITS-1:0]    reg_idx;
	logic [gnms_pkg::WIDTH_BITS-1:0]      width_clamp;
	logic [gnms_pkg::HEIGHT_BITS-1:0]     height_clamp;
	logic [gnms_pkg::PROD_BITS-1:0]       total;
	logic [gnms_pkg::CNT_BITS-1:0]        last_idx;
	gnms_pkg::geom_t                      geom_q;

	assign pready  = 1'b1;
	assign reg_idx = paddr[gnms_pkg::APB_ADDR_BITS-1:2];
	assign wr_en   = psel && penable && pwrite && pready;

	// A new width or height starts a new frame.
	assign restart = wr_en && (reg_idx == gnms_pkg::REG_IMAGE_WIDTH ||
		reg_idx == gnms_pkg::REG_IMAGE_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q      <= gnms_pkg::CFG_WIDTH_BITS'(gnms_pkg::RST_IMAGE_WIDTH);
			image_height_q     <= gnms_pkg::CFG_HEIGHT_BITS'(gnms_pkg::RST_IMAGE_HEIGHT);
			threshold_enable_q <= 1'b0;
			strong_threshold_q <= gnms_pkg::PIX_BITS'(gnms_pkg::RST_STRONG_THRESHOLD);
		end else if (wr_en) begin
			case (reg_idx)
				gnms_pkg::REG_IMAGE_WIDTH: begin
					image_width_q <= pwdata[gnms_pkg::CFG_WIDTH_BITS-1:0];
				end
				gnms_pkg::REG_IMAGE_HEIGHT: begin
					image_height_q <= pwdata[gnms_pkg::CFG_HEIGHT_BITS-1:0];
				end
				gnms_pkg::REG_THRESHOLD_ENABLE: begin
					threshold_enable_q <= pwdata[0];
				end
				gnms_pkg::REG_STRONG_THRESHOLD: begin
					strong_threshold_q <= pwdata[gnms_pkg::PIX_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			gnms_pkg::REG_IMAGE_WIDTH:      prdata = gnms_pkg::APB_DATA_BITS'(image_width_q);
			gnms_pkg::REG_IMAGE_HEIGHT:     prdata = gnms_pkg::APB_DATA_BITS'(image_height_q);
			gnms_pkg::REG_THRESHOLD_ENABLE: prdata = gnms_pkg::APB_DATA_BITS'(threshold_enable_q);
			gnms_pkg::REG_STRONG_THRESHOLD: prdata = gnms_pkg::APB_DATA_BITS'(strong_threshold_q);
			default:                        prdata = '0;
		endcase
	end

	always_comb begin
		if (image_width_q < gnms_pkg::MIN_DIM) begin
			width_clamp = gnms_pkg::WIDTH_BITS'(gnms_pkg::MIN_DIM);
		end else if (image_width_q > gnms_pkg::MAX_WIDTH) begin
			width_clamp = gnms_pkg::WIDTH_BITS'(gnms_pkg::MAX_WIDTH);
		end else begin
			width_clamp = gnms_pkg::WIDTH_BITS'(image_width_q);
		end
		if (image_height_q < gnms_pkg::MIN_DIM) begin
			height_clamp = gnms_pkg::HEIGHT_BITS'(gnms_pkg::MIN_DIM);
		end else if (image_height_q > gnms_pkg::MAX_HEIGHT) begin
			height_clamp = gnms_pkg::HEIGHT_BITS'(gnms_pkg::MAX_HEIGHT);
		end else begin
			height_clamp = gnms_pkg::HEIGHT_BITS'(image_height_q);
		end
	end

	assign total    = gnms_pkg::PROD_BITS'(width_clamp) * gnms_pkg::PROD_BITS'(height_clamp);
	assign last_idx = gnms_pkg::CNT_BITS'(total - gnms_pkg::PROD_BITS'(1));

	// The geometry is registered from the register fields and refreshed every cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_q.width      <= gnms_pkg::WIDTH_BITS'(gnms_pkg::RST_IMAGE_WIDTH);
			geom_q.height     <= gnms_pkg::HEIGHT_BITS'(gnms_pkg::RST_IMAGE_HEIGHT);
			geom_q.last_idx   <= gnms_pkg::CNT_BITS'(gnms_pkg::RST_LAST_IDX);
			geom_q.tail_start <= gnms_pkg::CNT_BITS'(gnms_pkg::RST_TAIL_START);
			geom_q.thresh_en  <= 1'b0;
			geom_q.strong_thr <= gnms_pkg::PIX_BITS'(gnms_pkg::RST_STRONG_THRESHOLD);
		end else begin
			geom_q.width      <= width_clamp;
			geom_q.height     <= height_clamp;
			geom_q.last_idx   <= last_idx;
			geom_q.tail_start <= last_idx - gnms_pkg::CNT_BITS'(width_clamp);
			geom_q.thresh_en  <= threshold_enable_q;
			geom_q.strong_thr <= strong_threshold_q;
		end
	end

	assign geom = geom_q;

endmodule

@@ rtl/gnms_suppress.sv @@
// ----------------------------------------------------------------------------
// gnms_suppress
// Compares the window centre with its two neighbors along the gradient sector
// and produces the suppressed, saturated or thresholded pixel value.
// ----------------------------------------------------------------------------
module gnms_suppress (
	input  gnms_pkg::win_t                    win,
	input  logic [gnms_pkg::SECT_BITS-1:0]    sector,
	input  logic                              interior,
	input  logic                              thresh_en,
	input  logic [gnms_pkg::PIX_BITS-1:0]     strong_thr,
	output logic [gnms_pkg::PIX_BITS-1:0]     value
);

	gnms_pkg::mag_t                nb_a;
	gnms_pkg::mag_t                nb_b;
	gnms_pkg::mag_t                nb_max;
	gnms_pkg::mag_t                centre;
	logic [gnms_pkg::PIX_BITS-1:0] sat;

	// Window rows run top to bottom, columns left to right.
	always_comb begin
		case (sector)
			gnms_pkg::SECT_HORZ: begin
				nb_a = win[1][0];
				nb_b = win[1][2];
			end
			gnms_pkg::SECT_RISE: begin
				nb_a = win[0][2];
				nb_b = win[2][0];
			end
			gnms_pkg::SECT_VERT: begin
				nb_a = win[0][1];
				nb_b = win[2][1];
			end
			default: begin
				nb_a = win[0][0];
				nb_b = win[2][2];
			end
		endcase
	end

	assign centre = win[1][1];
	assign nb_max = (nb_a > nb_b) ? nb_a : nb_b;

	always_comb begin
		if (!interior || centre < nb_max) begin
			sat = '0;
		end else if (centre > gnms_pkg::PIX_MAX) begin
			sat = gnms_pkg::PIX_BITS'(gnms_pkg::PIX_MAX);
		end else begin
			sat = centre[gnms_pkg::PIX_BITS-1:0];
		end
		if (thresh_en) begin
			value = (sat > strong_thr) ? gnms_pkg::PIX_BITS'(gnms_pkg::PIX_MAX) : '0;
		end else begin
			value = sat;
		end
	end

endmodule

@@ rtl/gradient_non_max_suppression.sv @@
// ----------------------------------------------------------------------------
// gradient_non_max_suppression
// Canny non-maximum suppression over a raster stream of gradient pixels.
// ----------------------------------------------------------------------------
// Usage:
// The item channel (item_valid, item_stall) carries one transaction per pixel
// with its magnitude and angle, or a flush tick (action high) that drains the
// tail of a frame. The result channel (result_valid, result_stall) returns at
// most one pixel_value per transaction, for the pixel one row and one column
// behind, with frame_last marking the final pixel of a frame.
// A transaction is registered at acceptance, the line store read completes in
// the same edge, and the window compare then runs from the working stage into
// the output register once that register is free.
// One item is accepted every cycle while the result side keeps up; a held
// result stalls the item side only once the working stage behind it is full.
// The first result of a frame appears with the pixel after the first row and
// one column; flush ticks emit the trailing border zeros.
// Reset clears the frame position and loads the default geometry of 640 x 480;
// line store contents not yet written in a frame only reach border pixels.
// Writing the width or height restarts the frame; write only while idle.
// ----------------------------------------------------------------------------
module gradient_non_max_suppression (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  logic                                 action,
	input  logic [gnms_pkg::MAG_BITS-1:0]        magnitude,
	input  logic [gnms_pkg::ANGLE_BITS-1:0]      angle_deg,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic [gnms_pkg::PIX_BITS-1:0]        pixel_value,
	output logic                                 frame_last,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [gnms_pkg::APB_ADDR_BITS-1:0]   paddr,
	input  logic [gnms_pkg::APB_DATA_BITS-1:0]   pwdata,
	output logic [gnms_pkg::APB_DATA_BITS-1:0]   prdata,
	output logic                                 pready
);

	gnms_pkg::geom_t                     geom;
	logic                                restart;

	logic                                accept;
	logic                                px_accept;
	logic                                s1_adv;
	logic                                s1_fire;
	logic                                px_fire;

	// Input position counters, advanced as pixel items are accepted.
	logic [gnms_pkg::COL_BITS-1:0]       in_column_q;
	logic [gnms_pkg::ROW_BITS-1:0]       in_row_q;
	logic [gnms_pkg::CNT_BITS-1:0]       in_lin_q;
	logic                                col_wrap;
	logic                                row_wrap;
	logic                                lin_wrap;

	// Working stage.
	logic                                s1_valid_q;
	logic                                action_s1;
	logic [gnms_pkg::MAG_BITS-1:0]       mag_s1;
	logic [gnms_pkg::ANGLE_BITS-1:0]     angle_s1;
	logic [gnms_pkg::COL_BITS-1:0]       col_s1;
	logic [gnms_pkg::ROW_BITS-1:0]       row_s1;
	logic [gnms_pkg::CNT_BITS-1:0]       lin_s1;

	// Line store.
	logic                                ram_we;
	logic [gnms_pkg::LINE_BITS-1:0]      ram_wdata;
	logic [gnms_pkg::LINE_BITS-1:0]      ram_rdata;
	gnms_pkg::mag_t                      rd_older;
	gnms_pkg::mag_t                      rd_newer;
	logic [gnms_pkg::SECT_BITS-1:0]      rd_sect;

	// Window columns that survive a shift, and the centre sector delay.
	gnms_pkg::mag_t [2:0]                win_mid_q;
	gnms_pkg::mag_t [2:0]                win_right_q;
	logic [gnms_pkg::SECT_BITS-1:0]      sector_dly_q;
	gnms_pkg::win_t                      win_next;
	logic                                interior;
	logic [gnms_pkg::PIX_BITS-1:0]       sup_value;

	// Output position and result selection.
	logic [gnms_pkg::CNT_BITS-1:0]       out_pixel_count_q;
	logic [gnms_pkg::CNT_BITS-1:0]       opc_next;
	logic                                emit_px;
	logic                                in_tail;
	logic                                has_res;
	logic [gnms_pkg::PIX_BITS-1:0]       res_val;
	logic                                res_last;

	logic                                result_valid_q;
	logic [gnms_pkg::PIX_BITS-1:0]       pixel_value_q;
	logic                                frame_last_q;

	gnms_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.geom    (geom),
		.restart (restart)
	);

	// Handshake: the working stage moves on whenever the output register is free.
	assign s1_adv     = !result_valid_q || !result_stall;
	assign item_stall = s1_valid_q && !s1_adv;
	assign accept     = item_valid && !item_stall;
	assign px_accept  = accept && (action == gnms_pkg::ACT_PIXEL);
	assign s1_fire    = s1_valid_q && s1_adv;
	assign px_fire    = s1_fire && (action_s1 == gnms_pkg::ACT_PIXEL);

	assign col_wrap = (gnms_pkg::WIDTH_BITS'(in_column_q) + gnms_pkg::WIDTH_BITS'(1)) ==
		geom.width;
	assign row_wrap = (gnms_pkg::HEIGHT_BITS'(in_row_q) + gnms_pkg::HEIGHT_BITS'(1)) ==
		geom.height;
	assign lin_wrap = in_lin_q == geom.last_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_column_q <= '0;
			in_row_q    <= '0;
			in_lin_q    <= '0;
		end else if (restart) begin
			in_column_q <= '0;
			in_row_q    <= '0;
			in_lin_q    <= '0;
		end else if (px_accept) begin
			if (col_wrap) begin
				in_column_q <= '0;
				in_row_q    <= row_wrap ? '0 : in_row_q + gnms_pkg::ROW_BITS'(1);
			end else begin
				in_column_q <= in_column_q + gnms_pkg::COL_BITS'(1);
			end
			in_lin_q <= lin_wrap ? '0 : in_lin_q + gnms_pkg::CNT_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= action;
			mag_s1    <= magnitude;
			angle_s1  <= angle_deg;
			col_s1    <= in_column_q;
			row_s1    <= in_row_q;
			lin_s1    <= in_lin_q;
		end
	end

	// The item in the working stage writes its column back as the next item reads
	// its own; consecutive pixels always sit in different columns.
	assign ram_we    = px_fire;
	assign ram_wdata = {gnms_pkg::sector_of(angle_s1), mag_s1, rd_newer};

	gnms_ram #(
		.WIDTH (gnms_pkg::LINE_BITS),
		.DEPTH (gnms_pkg::MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (col_s1),
		.wdata (ram_wdata),
		.re    (px_accept),
		.raddr (in_column_q),
		.rdata (ram_rdata)
	);

	assign rd_older = ram_rdata[gnms_pkg::MAG_BITS-1:0];
	assign rd_newer = ram_rdata[2*gnms_pkg::MAG_BITS-1:gnms_pkg::MAG_BITS];
	assign rd_sect  = ram_rdata[gnms_pkg::LINE_BITS-1:2*gnms_pkg::MAG_BITS];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			win_next[k][0] = win_mid_q[k];
			win_next[k][1] = win_right_q[k];
		end
		win_next[0][2] = rd_older;
		win_next[1][2] = rd_newer;
		win_next[2][2] = mag_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_mid_q    <= '0;
			win_right_q  <= '0;
			sector_dly_q <= gnms_pkg::SECT_HORZ;
		end else if (px_fire) begin
			for (int k = 0; k < 3; k++) begin
				win_mid_q[k]   <= win_right_q[k];
				win_right_q[k] <= win_next[k][2];
			end
			sector_dly_q <= rd_sect;
		end
	end

	// The output pixel sits one row and one column behind the input position, so
	// it lies inside the border exactly when both input coordinates are two or more.
	assign interior = (col_s1 >= gnms_pkg::COL_BITS'(2)) && (row_s1 >= gnms_pkg::ROW_BITS'(2));

	gnms_suppress u_suppress (
		.win        (win_next),
		.sector     (sector_dly_q),
		.interior   (interior),
		.thresh_en  (geom.thresh_en),
		.strong_thr (geom.strong_thr),
		.value      (sup_value)
	);

	assign emit_px = (action_s1 == gnms_pkg::ACT_PIXEL) &&
		(lin_s1 > gnms_pkg::CNT_BITS'(geom.width));
	assign in_tail = (out_pixel_count_q >= geom.tail_start) &&
		(out_pixel_count_q <= geom.last_idx);

	// Tail pixels are border pixels, which are zero in either output mode.
	always_comb begin
		has_res  = 1'b0;
		res_val  = sup_value;
		res_last = 1'b0;
		opc_next = out_pixel_count_q;
		if (emit_px) begin
			has_res  = 1'b1;
			opc_next = lin_s1 - gnms_pkg::CNT_BITS'(geom.width);
		end else if (in_tail) begin
			has_res  = 1'b1;
			res_val  = '0;
			res_last = out_pixel_count_q == geom.last_idx;
			opc_next = res_last ? '0 : out_pixel_count_q + gnms_pkg::CNT_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_pixel_count_q <= '0;
		end else if (restart) begin
			out_pixel_count_q <= '0;
		end else if (s1_fire) begin
			out_pixel_count_q <= opc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (s1_adv) begin
			result_valid_q <= s1_valid_q && has_res;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && has_res) begin
			pixel_value_q <= res_val;
			frame_last_q  <= res_last;
		end
	end

	assign result_valid = result_valid_q;
	assign pixel_value  = pixel_value_q;
	assign frame_last   = frame_last_q;

`ifndef SYNTHESIS
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> s1_valid_q && result_valid_q && result_stall)
		else $error("item side stalled without a blocked result");

	a_ram_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && px_accept |-> col_s1 != in_column_q)
		else $error("line store read and write hit the same column");

	a_column_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		gnms_pkg::WIDTH_BITS'(in_column_q) < geom.width)
		else $error("input column beyond the frame width");

	a_last_is_border: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && frame_last |-> pixel_value == '0)
		else $error("final pixel of a frame is not a border zero");

	a_out_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire |=> out_pixel_count_q <= $past(geom.last_idx))
		else $error("output pixel count beyond the frame");
`endif

endmodule

@@ tb/tb_gradient_non_max_suppression.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gradient_non_max_suppression
// Self-checking testbench for the gradient non-maximum suppression block. A
// behavioral line-store and window model predicts every result from the
// accepted pixel and flush transactions; results are compared in order. The
// run covers sector boundaries, border and tail handling, geometry clamping,
// threshold mode and random frames with bursty input and a stalling sink.
// ----------------------------------------------------------------------------
module tb_gradient_non_max_suppression;

	localparam int CLK_HALF      = 5;
	localparam int RESET_CYCLES  = 11;
	localparam int SETTLE_CYCLES = 8;
	localparam int IDLE_LIMIT    = 4000;
	localparam int RANDOM_PIXELS = 200;
	localparam int MAX_REPORTS   = 10;

	typedef struct packed {
		logic [gnms_pkg::PIX_BITS-1:0] value;
		logic                          last;
	} nms_pixel_t;

	logic                               clk          = 1'b0;
	logic                               arst_n       = 1'b0;
	logic                               item_valid   = 1'b0;
	logic                               item_stall;
	logic                               action       = gnms_pkg::ACT_PIXEL;
	logic [gnms_pkg::MAG_BITS-1:0]      magnitude    = '0;
	logic [gnms_pkg::ANGLE_BITS-1:0]    angle_deg    = '0;
	logic                               result_valid;
	logic                               result_stall = 1'b0;
	logic [gnms_pkg::PIX_BITS-1:0]      pixel_value;
	logic                               frame_last;
	logic                               psel         = 1'b0;
	logic                               penable      = 1'b0;
	logic                               pwrite       = 1'b0;
	logic [gnms_pkg::APB_ADDR_BITS-1:0] paddr        = '0;
	logic [gnms_pkg::APB_DATA_BITS-1:0] pwdata       = '0;
	logic [gnms_pkg::APB_DATA_BITS-1:0] prdata;
	logic                               pready;

	// Register copies as the block should hold them.
	logic [gnms_pkg::CFG_WIDTH_BITS-1:0]  cfg_width  =
		gnms_pkg::CFG_WIDTH_BITS'(gnms_pkg::RST_IMAGE_WIDTH);
	logic [gnms_pkg::CFG_HEIGHT_BITS-1:0] cfg_height =
		gnms_pkg::CFG_HEIGHT_BITS'(gnms_pkg::RST_IMAGE_HEIGHT);
	logic                                 cfg_thr_en = 1'b0;
	logic [gnms_pkg::PIX_BITS-1:0]        cfg_strong =
		gnms_pkg::PIX_BITS'(gnms_pkg::RST_STRONG_THRESHOLD);

	// Line stores, 3x3 window and raster position of the suppression model.
	bit [gnms_pkg::MAG_BITS-1:0]  older_row [gnms_pkg::MAX_WIDTH];
	bit [gnms_pkg::MAG_BITS-1:0]  newer_row [gnms_pkg::MAX_WIDTH];
	bit [gnms_pkg::SECT_BITS-1:0] sect_row  [gnms_pkg::MAX_WIDTH];
	bit [gnms_pkg::MAG_BITS-1:0]  win [3][3];
	bit [gnms_pkg::SECT_BITS-1:0] sect_delay;
	int unsigned                  col_pos;
	int unsigned                  row_pos;
	int unsigned                  out_cnt;

	nms_pixel_t expected_pixels [$];
	nms_pixel_t want;

	int unsigned burst_left;
	int          stall_mode;
	int unsigned stall_mode_left;
	int unsigned stall_run;
	int unsigned idle_cycles;
	int unsigned error_count;
	int unsigned results_checked;
	int unsigned frame_ends;
	int unsigned pixels_sent;
	int unsigned flushes_sent;
	int unsigned settings_count;

	gradient_non_max_suppression u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.action       (action),
		.magnitude    (magnitude),
		.angle_deg    (angle_deg),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.pixel_value  (pixel_value),
		.frame_last   (frame_last),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #CLK_HALF clk = ~clk;

	function automatic int unsigned eff_width();
		int unsigned w;
		w = cfg_width;
		if (w < gnms_pkg::MIN_DIM) w = gnms_pkg::MIN_DIM;
		if (w > gnms_pkg::MAX_WIDTH) w = gnms_pkg::MAX_WIDTH;
		return w;
	endfunction

	function automatic int unsigned eff_height();
		int unsigned h;
		h = cfg_height;
		if (h < gnms_pkg::MIN_DIM) h = gnms_pkg::MIN_DIM;
		if (h > gnms_pkg::MAX_HEIGHT) h = gnms_pkg::MAX_HEIGHT;
		return h;
	endfunction

	function automatic bit [gnms_pkg::SECT_BITS-1:0] angle_sector(
			input logic [gnms_pkg::ANGLE_BITS-1:0] ang);
		int unsigned d;
		d = ang % gnms_pkg::ANG_HALF;
		if (d < gnms_pkg::ANG_30 || d >= gnms_pkg::ANG_150) return gnms_pkg::SECT_HORZ;
		if (d < gnms_pkg::ANG_60) return gnms_pkg::SECT_RISE;
		if (d < gnms_pkg::ANG_120) return gnms_pkg::SECT_VERT;
		return gnms_pkg::SECT_FALL;
	endfunction

	function automatic logic [gnms_pkg::PIX_BITS-1:0] apply_threshold(
			input logic [gnms_pkg::PIX_BITS-1:0] v);
		if (cfg_thr_en) return (v > cfg_strong) ? gnms_pkg::PIX_BITS'(gnms_pkg::PIX_MAX) : '0;
		return v;
	endfunction

	// Border zeros of the frame tail, one per call while the tail is pending.
	task automatic emit_border_tail(input int unsigned total, input int unsigned w);
		nms_pixel_t px;
		if (out_cnt >= total - w - 1 && out_cnt < total) begin
			px.value = apply_threshold('0);
			px.last  = (out_cnt == total - 1);
			expected_pixels.push_back(px);
			out_cnt++;
			if (out_cnt >= total) out_cnt = 0;
		end
	endtask

	task automatic predict_suppression(input logic act,
			input logic [gnms_pkg::MAG_BITS-1:0] mag,
			input logic [gnms_pkg::ANGLE_BITS-1:0] ang);
		int unsigned                  w, h, total, c, r, n, idx, orow, ocol, k;
		bit [gnms_pkg::MAG_BITS-1:0]  up, mid, a, b, peak, centre;
		bit [gnms_pkg::SECT_BITS-1:0] centre_sect;
		logic [gnms_pkg::PIX_BITS-1:0] kept;
		nms_pixel_t                   px;
		w = eff_width();
		h = eff_height();
		total = w * h;
		if (act == gnms_pkg::ACT_FLUSH) begin
			emit_border_tail(total, w);
			return;
		end
		c = (col_pos < w) ? col_pos : 0;
		r = (row_pos < h) ? row_pos : 0;
		n = r * w + c;
		up = older_row[c];
		mid = newer_row[c];
		centre_sect = sect_delay;
		older_row[c] = mid;
		newer_row[c] = mag;
		sect_delay = sect_row[c];
		sect_row[c] = angle_sector(ang);
		for (k = 0; k < 3; k++) begin
			win[k][0] = win[k][1];
			win[k][1] = win[k][2];
		end
		win[0][2] = up;
		win[1][2] = mid;
		win[2][2] = mag;
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h) r = 0;
		end
		col_pos = c;
		row_pos = r;
		if (n >= w + 1) begin
			// The window centre is the pixel one row and one column behind.
			idx = n - w - 1;
			orow = idx / w;
			ocol = idx % w;
			kept = '0;
			if (orow != 0 && orow != h - 1 && ocol != 0 && ocol != w - 1) begin
				centre = win[1][1];
				case (centre_sect)
					gnms_pkg::SECT_HORZ: begin
						a = win[1][0];
						b = win[1][2];
					end
					gnms_pkg::SECT_RISE: begin
						a = win[0][2];
						b = win[2][0];
					end
					gnms_pkg::SECT_VERT: begin
						a = win[0][1];
						b = win[2][1];
					end
					default: begin
						a = win[0][0];
						b = win[2][2];
					end
				endcase
				peak = (a > b) ? a : b;
				if (centre >= peak)
					kept = (centre > gnms_pkg::PIX_MAX) ?
						gnms_pkg::PIX_BITS'(gnms_pkg::PIX_MAX) :
						centre[gnms_pkg::PIX_BITS-1:0];
			end
			px.value = apply_threshold(kept);
			px.last  = 1'b0;
			expected_pixels.push_back(px);
			out_cnt = idx + 1;
		end else begin
			emit_border_tail(total, w);
		end
	endtask

	function automatic logic [gnms_pkg::MAG_BITS-1:0] rand_magnitude();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (sel == 0) return '0;
		if (sel == 1) return gnms_pkg::MAG_BITS'($urandom_range(1900, 2047));
		if (sel < 8) return gnms_pkg::MAG_BITS'($urandom_range(0, 300));
		return gnms_pkg::MAG_BITS'($urandom_range(0, 2047));
	endfunction

	// Mostly uniform angles, sometimes right at or just below a sector edge.
	function automatic logic [gnms_pkg::ANGLE_BITS-1:0] rand_angle();
		int unsigned e;
		if ($urandom_range(0, 5) != 0) return gnms_pkg::ANGLE_BITS'($urandom_range(0, 359));
		case ($urandom_range(0, 9))
			0: e = 0;
			1: e = gnms_pkg::ANG_30;
			2: e = gnms_pkg::ANG_60;
			3: e = gnms_pkg::ANG_120;
			4: e = gnms_pkg::ANG_150;
			5: e = gnms_pkg::ANG_HALF;
			6: e = gnms_pkg::ANG_HALF + gnms_pkg::ANG_30;
			7: e = gnms_pkg::ANG_HALF + gnms_pkg::ANG_60;
			8: e = gnms_pkg::ANG_HALF + gnms_pkg::ANG_120;
			default: e = gnms_pkg::ANG_HALF + gnms_pkg::ANG_150;
		endcase
		if ($urandom_range(0, 1) == 0) e = (e == 0) ? 359 : e - 1;
		return gnms_pkg::ANGLE_BITS'(e);
	endfunction

	task automatic send_item(input logic act, input logic [gnms_pkg::MAG_BITS-1:0] mag,
			input logic [gnms_pkg::ANGLE_BITS-1:0] ang);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
				: $urandom_range(1, 30);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		item_valid <= 1'b1;
		action <= act;
		magnitude <= mag;
		angle_deg <= ang;
		do @(posedge clk); while (item_stall);
		predict_suppression(act, mag, ang);
		if (act == gnms_pkg::ACT_FLUSH) flushes_sent++;
		else pixels_sent++;
	endtask

	task automatic send_pixels(input int unsigned count, input bit noisy);
		int unsigned k;
		for (k = 0; k < count; k++) begin
			if (noisy && $urandom_range(0, 24) == 0)
				send_item(gnms_pkg::ACT_FLUSH, gnms_pkg::MAG_BITS'($urandom()),
					gnms_pkg::ANGLE_BITS'($urandom_range(0, 359)));
			send_item(gnms_pkg::ACT_PIXEL, rand_magnitude(), rand_angle());
		end
	endtask

	task automatic send_flushes(input int unsigned count);
		int unsigned k;
		for (k = 0; k < count; k++)
			send_item(gnms_pkg::ACT_FLUSH, gnms_pkg::MAG_BITS'($urandom()),
				gnms_pkg::ANGLE_BITS'($urandom_range(0, 359)));
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Unused upper bits of the data word carry random junk.
	task automatic reg_write(input logic [gnms_pkg::REG_IDX_BITS-1:0] idx,
			input int unsigned field);
		logic [gnms_pkg::APB_DATA_BITS-1:0] data;
		data = $urandom();
		case (idx)
			gnms_pkg::REG_IMAGE_WIDTH:
				data[gnms_pkg::CFG_WIDTH_BITS-1:0] = field[gnms_pkg::CFG_WIDTH_BITS-1:0];
			gnms_pkg::REG_IMAGE_HEIGHT:
				data[gnms_pkg::CFG_HEIGHT_BITS-1:0] = field[gnms_pkg::CFG_HEIGHT_BITS-1:0];
			gnms_pkg::REG_THRESHOLD_ENABLE:
				data[0] = field[0];
			default:
				data[gnms_pkg::PIX_BITS-1:0] = field[gnms_pkg::PIX_BITS-1:0];
		endcase
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			gnms_pkg::REG_IMAGE_WIDTH: begin
				cfg_width = data[gnms_pkg::CFG_WIDTH_BITS-1:0];
				col_pos = 0;
				row_pos = 0;
				out_cnt = 0;
			end
			gnms_pkg::REG_IMAGE_HEIGHT: begin
				cfg_height = data[gnms_pkg::CFG_HEIGHT_BITS-1:0];
				col_pos = 0;
				row_pos = 0;
				out_cnt = 0;
			end
			gnms_pkg::REG_THRESHOLD_ENABLE: cfg_thr_en = data[0];
			default:                        cfg_strong = data[gnms_pkg::PIX_BITS-1:0];
		endcase
		@(posedge clk);
	endtask

	task automatic test_default_geometry();
		settings_count++;
		send_pixels(gnms_pkg::RST_IMAGE_WIDTH + 8, 1'b0);
	endtask

	task automatic test_directed_sectors();
		int unsigned mags [16];
		int unsigned angs [16];
		int unsigned k;
		mags = '{0, 2047, 100, 7, 50, 300, 256, 40, 1, 255, 254, 1024, 2047, 60, 80, 0};
		angs = '{0, 29, 30, 59, 60, 119, 120, 149, 150, 179, 215, 209, 210, 270, 330, 359};
		wait_drained();
		reg_write(gnms_pkg::REG_IMAGE_WIDTH, 4);
		reg_write(gnms_pkg::REG_IMAGE_HEIGHT, 4);
		reg_write(gnms_pkg::REG_THRESHOLD_ENABLE, 0);
		reg_write(gnms_pkg::REG_STRONG_THRESHOLD, gnms_pkg::RST_STRONG_THRESHOLD);
		settings_count++;
		for (k = 0; k < 16; k++)
			send_item(gnms_pkg::ACT_PIXEL, gnms_pkg::MAG_BITS'(mags[k]),
				gnms_pkg::ANGLE_BITS'(angs[k]));
		// The tail takes width + 1 flushes; the last one finds nothing pending.
		send_flushes(6);
	endtask

	task automatic test_geometry_clamp_and_tail();
		int unsigned k;
		wait_drained();
		reg_write(gnms_pkg::REG_IMAGE_WIDTH, 0);
		reg_write(gnms_pkg::REG_IMAGE_HEIGHT, 1);
		reg_write(gnms_pkg::REG_THRESHOLD_ENABLE, 1);
		reg_write(gnms_pkg::REG_STRONG_THRESHOLD, 0);
		settings_count++;
		for (k = 0; k < 9; k++)
			send_item(gnms_pkg::ACT_PIXEL, gnms_pkg::MAG_BITS'((k == 4) ? 200 : 5),
				gnms_pkg::ANGLE_BITS'(45 * k));
		// No flush: the next frame's first pixels push out the previous tail.
		send_pixels(4, 1'b0);
		send_flushes(1);
	endtask

	task automatic pick_random_setting();
		int unsigned w, h, sel;
		sel = $urandom_range(0, 9);
		if (sel == 0) w = $urandom_range(0, 2);
		else if (sel < 6) w = $urandom_range(3, 8);
		else w = $urandom_range(9, 40);
		sel = $urandom_range(0, 9);
		if (sel == 0) h = $urandom_range(0, 2);
		else if (sel < 8) h = $urandom_range(3, 6);
		else h = $urandom_range(7, 12);
		sel = $urandom_range(0, 4);
		if (sel <= 2) reg_write(gnms_pkg::REG_IMAGE_WIDTH, w);
		if (sel <= 1 || sel == 3) reg_write(gnms_pkg::REG_IMAGE_HEIGHT, h);
		reg_write(gnms_pkg::REG_THRESHOLD_ENABLE, $urandom_range(0, 1));
		sel = $urandom_range(0, 3);
		reg_write(gnms_pkg::REG_STRONG_THRESHOLD, (sel == 0) ? 0 :
			(sel == 1) ? gnms_pkg::PIX_MAX : $urandom_range(0, gnms_pkg::PIX_MAX));
		settings_count++;
	endtask

	task automatic test_random_frames();
		int unsigned start, w, h, npix, ending;
		start = pixels_sent;
		while (pixels_sent - start < RANDOM_PIXELS) begin
			wait_drained();
			pick_random_setting();
			w = eff_width();
			h = eff_height();
			// Some frames are cut short, some end without a flush.
			ending = $urandom_range(0, 9);
			npix = (ending < 2) ? $urandom_range(1, w * h - 1) : w * h;
			send_pixels(npix, 1'b1);
			if (ending >= 4) send_flushes(w + 1 + $urandom_range(0, 2));
		end
	endtask

	// An oversized width is clamped to the line store depth; the first results
	// only appear once a full clamped row and two more pixels have gone in.
	task automatic test_extreme_geometry();
		wait_drained();
		reg_write(gnms_pkg::REG_IMAGE_WIDTH, 2047);
		reg_write(gnms_pkg::REG_IMAGE_HEIGHT, 3);
		reg_write(gnms_pkg::REG_THRESHOLD_ENABLE, 0);
		settings_count++;
		send_pixels(gnms_pkg::MAX_WIDTH + 8, 1'b0);
		send_flushes(2);
	endtask

	// Sink stall pattern: quiet stretches, random stalls and long stall runs.
	always @(posedge clk) begin
		if (stall_mode_left == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_mode_left <= $urandom_range(64, 512);
		end else begin
			stall_mode_left <= stall_mode_left - 1;
		end
		case (stall_mode)
			0: result_stall <= 1'b0;
			1: result_stall <= ($urandom_range(0, 99) < 30);
			default: begin
				if (stall_run == 0) begin
					result_stall <= ~result_stall;
					stall_run <= result_stall ? $urandom_range(0, 6) : $urandom_range(1, 20);
				end else begin
					stall_run <= stall_run - 1;
				end
			end
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (expected_pixels.size() == 0) begin
				error_count++;
				if (error_count <= MAX_REPORTS)
					$display("Unexpected result transaction: pixel_value %0d frame_last %0b",
						pixel_value, frame_last);
			end else begin
				want = expected_pixels.pop_front();
				results_checked++;
				if (want.last) frame_ends++;
				if (pixel_value !== want.value || frame_last !== want.last) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$display("Result %0d: expected pixel_value %0d frame_last %0b, got %0d %0b",
							results_checked, want.value, want.last, pixel_value, frame_last);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)
				|| (psel && penable)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
				idle_cycles, expected_pixels.size());
			$display("CHECK FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_default_geometry();
		test_directed_sectors();
		test_geometry_clamp_and_tail();
		test_random_frames();
		test_extreme_geometry();
		wait_drained();
		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d pixel and %0d flush transactions over %0d register settings.",
			pixels_sent, flushes_sent, settings_count);
		$display("Checked %0d results, %0d of them frame ends.", results_checked, frame_ends);
		if (error_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches in total.", error_count);
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/gnms_pkg.sv
rtl/gnms_ram.sv
rtl/gnms_regs.sv
rtl/gnms_suppress.sv
rtl/gradient_non_max_suppression.sv
tb/tb_gradient_non_max_suppression.sv
